### design/nri_pkg.sv
// Shared types and codes for the negacyclic ring inverse FFT unit.
package nri_pkg;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_OUT,
    S_BF_RDU,
    S_BF_RDV,
    S_BF_CAPV,
    S_BF_CALC,
    S_BF_WRU,
    S_BF_WRV
  } state_t;

  // Source of the RAM write data
  typedef enum logic [1:0] {
    WSRC_LOAD,
    WSRC_SUM,
    WSRC_DIFF
  } wsrc_t;

  // Result status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_EVEN_MOD    = 3'd1;
  localparam logic [2:0] ST_T_OVER_2D   = 3'd2;
  localparam logic [2:0] ST_COEFF_RANGE = 3'd3;
  localparam logic [2:0] ST_NO_DATA     = 3'd4;

  // Input word kinds
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_LOG_RING = 2'd0;
  localparam logic [1:0] REG_LOG_POLY = 2'd1;
  localparam logic [1:0] REG_MODULUS  = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       wr_en;
    logic       wr_bank;
    wsrc_t      wsrc;
    logic       rd_bank;
    logic       cap_a;
    logic       cap_b;
    logic       neg;
    logic       calc;
    logic       out_load;
    logic       out_last;
    logic [2:0] out_status;
  } cmd_t;

endpackage

### design/nri_ram.sv
// Generic single write port RAM with one registered read port.
module nri_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/nri_datapath.sv
// Datapath: two coefficient banks, butterfly arithmetic mod p and the output register.
module nri_datapath import nri_pkg::*; #(
  parameter int MAX_LOG_RING  = 8,
  parameter int MAX_LOG_POLYS = 4,
  parameter int COEFF_BITS    = 32,
  localparam int AW = MAX_LOG_RING + MAX_LOG_POLYS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  input  logic [COEFF_BITS-1:0] p,
  input  logic [COEFF_BITS-1:0] in_coeff,
  input  logic [AW-1:0]         rd_addr,
  input  logic [AW-1:0]         wr_addr,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [COEFF_BITS-1:0] out_coeff,
  output logic [2:0]            out_status,
  output logic                  out_last
);

  localparam int CB = COEFF_BITS;

  logic          rsel;
  logic [CB-1:0] rdata0, rdata1, rdata;
  logic [CB-1:0] a_reg, b_reg, sum_reg, diff_reg;
  logic [CB-1:0] b_val, sum_mod, diff_mod, wdata;
  logic [CB:0]   sum_wide;

  // Halve a residue mod odd p
  function automatic logic [CB-1:0] halve(input logic [CB-1:0] x, input logic [CB-1:0] m);
    logic [CB:0] w;
    w = x[0] ? ({1'b0, x} + {1'b0, m}) : {1'b0, x};
    return CB'(w >> 1);
  endfunction

  nri_ram #(.WIDTH(CB), .DEPTH(1 << AW)) u_bank0 (
    .clk   (clk),
    .we    (cmd.wr_en && !cmd.wr_bank),
    .waddr (wr_addr),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rdata0)
  );

  nri_ram #(.WIDTH(CB), .DEPTH(1 << AW)) u_bank1 (
    .clk   (clk),
    .we    (cmd.wr_en && cmd.wr_bank),
    .waddr (wr_addr),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rdata1)
  );

  // Follow the bank of the read in flight
  always_ff @(posedge clk) begin
    rsel <= cmd.rd_bank;
  end
  assign rdata = rsel ? rdata1 : rdata0;

  // Negate the shifted operand where it wrapped
  assign b_val = (cmd.neg && rdata != '0) ? (p - rdata) : rdata;

  // Modular sum and difference
  assign sum_wide = {1'b0, a_reg} + {1'b0, b_reg};
  assign sum_mod  = (sum_wide >= {1'b0, p}) ? CB'(sum_wide - {1'b0, p}) : CB'(sum_wide);
  assign diff_mod = (a_reg >= b_reg) ? (a_reg - b_reg)
                  : CB'({1'b0, a_reg} + {1'b0, p} - {1'b0, b_reg});

  // Operand and result registers
  always_ff @(posedge clk) begin
    if (cmd.cap_a) begin
      a_reg <= rdata;
    end
    if (cmd.cap_b) begin
      b_reg <= b_val;
    end
    if (cmd.calc) begin
      sum_reg  <= sum_mod;
      diff_reg <= diff_mod;
    end
  end

  // Select write data
  always_comb begin
    case (cmd.wsrc)
      WSRC_LOAD: wdata = in_coeff;
      WSRC_SUM:  wdata = halve(sum_reg, p);
      WSRC_DIFF: wdata = halve(diff_reg, p);
      default:   wdata = '0;
    endcase
  end

  // Output register: load on command, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_coeff  <= (cmd.out_status == ST_OK) ? rdata : '0;
      out_status <= cmd.out_status;
      out_last   <= cmd.out_last;
    end
  end

endmodule

### design/nri_ctrl.sv
// Controller: configuration, load and read counters, butterfly sequencer.
module nri_ctrl import nri_pkg::*; #(
  parameter int MAX_LOG_RING  = 8,
  parameter int MAX_LOG_POLYS = 4,
  parameter int COEFF_BITS    = 32,
  localparam int AW = MAX_LOG_RING + MAX_LOG_POLYS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  input  logic                  in_valid,
  input  logic                  in_mode,
  input  logic [COEFF_BITS-1:0] in_coeff,
  input  logic                  out_busy,
  output logic                  in_ready,
  output logic [COEFF_BITS-1:0] p,
  output logic [AW-1:0]         rd_addr,
  output logic [AW-1:0]         wr_addr,
  output cmd_t                  cmd
);

  localparam int ML   = MAX_LOG_RING;
  localparam int MP   = MAX_LOG_POLYS;
  localparam int CNTW = AW + 1;
  localparam int LDW  = $clog2(ML + 1);
  localparam int LTW  = $clog2(MP + 1);

  state_t          state, state_next;
  logic [3:0]      ld_reg;
  logic [2:0]      lt_reg;
  logic [31:0]     mod_reg;
  logic [CNTW-1:0] load_count, read_count;
  logic [2:0]      err;
  logic            set_ready, res_bank, range_bad;
  logic [LTW-1:0]  stage;
  logic [MP-1:0]   m;
  logic [ML-1:0]   k;
  logic [2:0]      pend_status;
  logic            pend_last;

  logic [LDW-1:0]  ld_e;
  logic [LTW-1:0]  lt_e;
  logic [CNTW-1:0] n_m1;
  logic [ML-1:0]   dm, e, sh, idx;
  logic [MP-1:0]   mm1, half_m, one_s, j, u_row, v_row, su_row, sv_row;
  logic            accept, last_load, read_last, range_bad_now, do_xform;
  logic            bneg, bf_done, src_bank;
  logic [2:0]      fin_err;

  function automatic logic [MP-1:0] rev_full(input logic [MP-1:0] v);
    logic [MP-1:0] r;
    for (int i = 0; i < MP; i++) begin
      r[i] = v[MP-1-i];
    end
    return r;
  endfunction

  function automatic logic [AW-1:0] mk_addr(input logic [MP-1:0] row, input logic [ML-1:0] col,
                                            input logic [LDW-1:0] sft);
    return AW'((AW'(row) << sft) | AW'(col));
  endfunction

  // Effective sizes, saturated
  assign ld_e = (int'(ld_reg) > ML) ? LDW'(ML) : LDW'(ld_reg);
  assign lt_e = (int'(lt_reg) > MP) ? LTW'(MP) : LTW'(lt_reg);
  assign p    = mod_reg[COEFF_BITS-1:0];
  assign n_m1 = CNTW'(CNTW'(1) << (int'(ld_e) + int'(lt_e))) - CNTW'(1);
  assign dm   = ML'(((ML+1)'(1) << ld_e) - (ML+1)'(1));
  assign mm1  = MP'((((MP+1)'(1) << lt_e) >> 1) - (MP+1)'(1));

  assign in_ready  = (state == S_IDLE) && !out_busy;
  assign accept    = in_valid && in_ready;
  assign last_load = (load_count == n_m1);
  assign read_last = (read_count == n_m1);

  // Set checks, in priority order
  assign range_bad_now = ((load_count == '0) ? 1'b0 : range_bad) | (in_coeff >= p);
  always_comb begin
    if (int'(lt_e) > int'(ld_e) + 1) begin
      fin_err = ST_T_OVER_2D;
    end else if (lt_e == '0) begin
      fin_err = ST_OK;
    end else if (!p[0]) begin
      fin_err = ST_EVEN_MOD;
    end else if (range_bad_now) begin
      fin_err = ST_COEFF_RANGE;
    end else begin
      fin_err = ST_OK;
    end
  end
  assign do_xform = (fin_err == ST_OK) && (lt_e != '0);

  // Butterfly row pair and negacyclic shift of the current step
  assign one_s  = MP'((MP+1)'(1) << stage);
  assign half_m = one_s - MP'(1);
  assign j      = m & half_m;
  assign u_row  = MP'(((m & ~half_m) << 1) | j);
  assign v_row  = u_row | one_s;
  assign e      = ML'(AW'(j) << (int'(ld_e) - int'(stage)));
  assign sh     = (j == '0) ? '0 : ML'(((ML+1)'(1) << ld_e) - (ML+1)'(e));
  assign idx    = (k - sh) & dm;
  assign bneg   = (k < sh) ^ (j != '0);
  assign su_row = (stage == '0) ? (rev_full(u_row) >> (MP - int'(lt_e))) : u_row;
  assign sv_row = (stage == '0) ? (rev_full(v_row) >> (MP - int'(lt_e))) : v_row;
  assign src_bank = stage[0];
  assign bf_done  = (k == dm) && (m == mm1) && (stage == LTW'(lt_e - LTW'(1)));

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.wsrc   = WSRC_LOAD;
    cmd.rd_bank = res_bank;
    rd_addr    = read_count[AW-1:0];
    wr_addr    = load_count[AW-1:0];
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_mode == MODE_LOAD) begin
            cmd.wr_en = 1'b1;
            if (last_load && do_xform) begin
              state_next = S_BF_RDU;
            end
          end else begin
            state_next = S_RD_OUT;
          end
        end
      end
      S_RD_OUT: begin
        cmd.out_load   = 1'b1;
        cmd.out_last   = pend_last;
        cmd.out_status = pend_status;
        state_next     = S_IDLE;
      end
      S_BF_RDU: begin
        cmd.rd_bank = src_bank;
        rd_addr     = mk_addr(su_row, k, ld_e);
        state_next  = S_BF_RDV;
      end
      S_BF_RDV: begin
        cmd.rd_bank = src_bank;
        cmd.cap_a   = 1'b1;
        rd_addr     = mk_addr(sv_row, idx, ld_e);
        state_next  = S_BF_CAPV;
      end
      S_BF_CAPV: begin
        cmd.rd_bank = src_bank;
        cmd.cap_b   = 1'b1;
        cmd.neg     = bneg;
        state_next  = S_BF_CALC;
      end
      S_BF_CALC: begin
        cmd.calc   = 1'b1;
        state_next = S_BF_WRU;
      end
      S_BF_WRU: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_bank = ~src_bank;
        cmd.wsrc    = WSRC_SUM;
        wr_addr     = mk_addr(u_row, k, ld_e);
        state_next  = S_BF_WRV;
      end
      S_BF_WRV: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_bank = ~src_bank;
        cmd.wsrc    = WSRC_DIFF;
        wr_addr     = mk_addr(v_row, k, ld_e);
        state_next  = bf_done ? S_IDLE : S_BF_RDU;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Configuration, counters and set status
  always_ff @(posedge clk) begin
    if (rst) begin
      ld_reg      <= '0;
      lt_reg      <= '0;
      mod_reg     <= 32'd3;
      load_count  <= '0;
      read_count  <= '0;
      err         <= ST_OK;
      set_ready   <= 1'b0;
      res_bank    <= 1'b0;
      range_bad   <= 1'b0;
      stage       <= '0;
      m           <= '0;
      k           <= '0;
      pend_status <= ST_OK;
      pend_last   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && in_mode == MODE_LOAD) begin
            set_ready  <= 1'b0;
            read_count <= '0;
            range_bad  <= range_bad_now;
            if (last_load) begin
              load_count <= '0;
              err        <= fin_err;
              stage      <= '0;
              m          <= '0;
              k          <= '0;
              res_bank   <= do_xform ? lt_e[0] : 1'b0;
              set_ready  <= !do_xform;
            end else begin
              load_count <= load_count + CNTW'(1);
            end
          end else if (accept) begin
            if (!set_ready) begin
              pend_status <= ST_NO_DATA;
              pend_last   <= 1'b0;
            end else begin
              pend_status <= err;
              pend_last   <= read_last;
              if (read_last) begin
                read_count <= '0;
                set_ready  <= 1'b0;
              end else begin
                read_count <= read_count + CNTW'(1);
              end
            end
          end
        end
        S_BF_WRV: begin
          if (k != dm) begin
            k <= k + ML'(1);
          end else begin
            k <= '0;
            if (m != mm1) begin
              m <= m + MP'(1);
            end else begin
              m <= '0;
              if (bf_done) begin
                set_ready  <= 1'b1;
                read_count <= '0;
              end else begin
                stage <= stage + LTW'(1);
              end
            end
          end
        end
        default: begin
        end
      endcase
      // Register write: abort any partial load and drop pending results
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_LOG_RING: ld_reg  <= cfg_data[3:0];
          REG_LOG_POLY: lt_reg  <= cfg_data[2:0];
          REG_MODULUS:  mod_reg <= cfg_data;
          default: begin
          end
        endcase
        if (cfg_index == REG_LOG_RING || cfg_index == REG_LOG_POLY ||
            cfg_index == REG_MODULUS) begin
          load_count <= '0;
          read_count <= '0;
          set_ready  <= 1'b0;
          err        <= ST_OK;
        end
      end
    end
  end

endmodule

### design/negacyclic_ring_inverse_fft_unit.sv
// Top level of the negacyclic ring inverse FFT unit.
//
// Usage: write log_ring_degree (index 0), log_poly_count (index 1) and
// modulus (index 2) on the cfg port while the unit is idle. Then stream in
// d*t load words (s_tuser = 0, coefficient in s_tdata) in row-major order.
// After the last load the set is checked and, for t > 1 if the checks pass,
// transformed between the two coefficient banks. Read words (s_tuser = 1)
// each return one result on the master side: m_tdata the coefficient,
// m_tuser the status, m_tlast on the final one. A read passes through state
// S_RD_OUT and the registered bank read into the output register. One word
// is handled at a time, and the slave side stays closed while a result sits
// unread in the output register. The transform steps each butterfly pair
// through states S_BF_RDU to S_BF_WRV, as each coefficient bank has a single
// read port. Reset clears configuration to defaults and leaves no data: a
// read then gives status 4. When the receiver stalls, the result holds in
// the output register and no further word is taken.
module negacyclic_ring_inverse_fft_unit import nri_pkg::*; #(
  parameter int MAX_LOG_RING  = 8,
  parameter int MAX_LOG_POLYS = 4,
  parameter int COEFF_BITS    = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // coeff_in
  input  logic [0:0]  s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // coeff_out
  output logic [2:0]  m_tuser,   // status
  output logic        m_tlast    // is_last
);

  localparam int AW = MAX_LOG_RING + MAX_LOG_POLYS;

  cmd_t                  cmd;
  logic [COEFF_BITS-1:0] p, in_coeff, out_coeff;
  logic [AW-1:0]         rd_addr, wr_addr;

  assign in_coeff = s_tdata[COEFF_BITS-1:0];
  assign m_tdata  = 32'(out_coeff);

  nri_ctrl #(
    .MAX_LOG_RING  (MAX_LOG_RING),
    .MAX_LOG_POLYS (MAX_LOG_POLYS),
    .COEFF_BITS    (COEFF_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_tvalid),
    .in_mode   (s_tuser[0]),
    .in_coeff  (in_coeff),
    .out_busy  (m_tvalid),
    .in_ready  (s_tready),
    .p         (p),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .cmd       (cmd)
  );

  nri_datapath #(
    .MAX_LOG_RING  (MAX_LOG_RING),
    .MAX_LOG_POLYS (MAX_LOG_POLYS),
    .COEFF_BITS    (COEFF_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .p          (p),
    .in_coeff   (in_coeff),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_coeff  (out_coeff),
    .out_status (m_tuser),
    .out_last   (m_tlast)
  );

endmodule
